FILE: rtl/work_stealing_task_deque_unit_assert.svh
// Assertion macros shared by the task deque RTL.
// Included by wstd_ctrl and work_stealing_task_deque_unit; no dependencies.
`ifndef WORK_STEALING_TASK_DEQUE_UNIT_ASSERT_SVH
`define WORK_STEALING_TASK_DEQUE_UNIT_ASSERT_SVH

// generic form: label, clock, reset, property body
`define WSTD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("task deque assertion failed");

// short form on the block's own clock and reset
`define WSTD_ASSERT_CK(lbl, prop) `WSTD_ASSERT(lbl, clock, reset, prop)

`endif

FILE: rtl/wstd_pkg.sv
// Package for the work-stealing task deque: sizes, codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package wstd_pkg;

   // ring depth, power of two; counters carry one extra wrap bit
   localparam int DEPTH    = 256;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int HANDLE_W = 48;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_STEAL = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic              take;
      logic [FILL_W-1:0] fill;
   } op_result_type;

endpackage

FILE: rtl/wstd_req_if.sv
// Request channel of the task deque: valid/ready plus operation word.
// Depends on wstd_pkg.
`timescale 1ns / 1ps

interface wstd_req_if
   import wstd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [HANDLE_W-1:0] task_handle;

   modport source (output valid, output func, output task_handle, input ready);
   modport sink   (input valid, input func, input task_handle, output ready);
endinterface

FILE: rtl/wstd_rsp_if.sv
// Response channel of the task deque: valid/ready plus result word.
// Depends on wstd_pkg.
`timescale 1ns / 1ps

interface wstd_rsp_if
   import wstd_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] task_out;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output status, output task_out, output fill_count,
                   input ready);
   modport sink   (input valid, input status, input task_out, input fill_count,
                   output ready);
endinterface

FILE: rtl/work_stealing_task_deque_unit.sv
// Work-stealing task deque, top level: control, handle RAM and result stages.
// Requests pass stage s1 (with the RAM's registered read), then the response register.
// Throughput: one operation per cycle while the response side is not stalled.
// Reset (synchronous, active high) empties the deque and clears both stages;
// the handle RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "work_stealing_task_deque_unit_assert.svh"

module work_stealing_task_deque_unit
   import wstd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   wstd_req_if.sink   req,
   wstd_rsp_if.source rsp
);

   mem_req_type         mem_req;
   op_result_type       op_result;
   logic                accept;
   logic                rsp_free;
   logic                s1_adv;
   logic [HANDLE_W-1:0] rd_data;

   logic                s1_valid_ff, s1_valid_in;
   op_result_type       s1_res_ff, s1_res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_task_ff, rsp_task_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && rsp_free;
   assign req.ready = !s1_valid_ff || rsp_free;
   assign accept    = req.valid && req.ready;

   wstd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req.func),
      .mem_req (mem_req),
      .result  (op_result)
   );

   wstd_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.addr),
      .wr_data (req.task_handle),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in   = req.ready ? req.valid : s1_valid_ff;
      s1_res_in     = accept ? op_result : s1_res_ff;
      rsp_valid_in  = rsp_free ? s1_valid_ff : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (s1_adv) begin
         rsp_status_in = s1_res_ff.status;
         rsp_task_in   = s1_res_ff.take ? rd_data : '0;
         rsp_fill_in   = s1_res_ff.fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_res_ff     <= s1_res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.task_out   = rsp_task_ff;
   assign rsp.fill_count = rsp_fill_ff;

   `WSTD_ASSERT_CK(a_no_task_on_fail,
      ((rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_task_ff == '0)))
   `WSTD_ASSERT_CK(a_s1_held_on_stall, ((s1_valid_ff && !rsp_free) |=> s1_valid_ff))
   `WSTD_ASSERT_CK(a_one_mem_access, ($onehot0({mem_req.wr_en, mem_req.rd_en})))

endmodule

FILE: rtl/wstd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wstd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/wstd_ctrl.sv
// Head/tail counters and operation decode of the task deque.
// Depends on wstd_pkg and work_stealing_task_deque_unit_assert.svh.
`timescale 1ns / 1ps
`include "work_stealing_task_deque_unit_assert.svh"

module wstd_ctrl
   import wstd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [FUNC_W-1:0] func,
   output mem_req_type       mem_req,
   output op_result_type     result
);

   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill;
   logic [CNT_W-1:0] fill_after;
   logic [CNT_W-1:0] tail_dec;
   logic             full;
   logic             empty;

   assign fill     = tail_ff - head_ff;
   assign tail_dec = tail_ff - 1'b1;
   assign full     = fill >= CNT_W'(DEPTH - 1);
   assign empty    = fill == '0;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      mem_req.addr  = tail_ff[ADDR_W-1:0];
      result.status = STATUS_OK;
      result.take   = 1'b0;
      case (func_type'(func))
         FUNC_PUSH: begin
            if (full) begin
               result.status = STATUS_FULL;
            end else begin
               mem_req.wr_en = accept;
               tail_in       = tail_ff + 1'b1;
            end
         end
         FUNC_POP: begin
            if (empty) begin
               result.status = STATUS_EMPTY;
               head_in       = '0;
               tail_in       = '0;
            end else begin
               mem_req.rd_en = accept;
               mem_req.addr  = tail_dec[ADDR_W-1:0];
               result.take   = 1'b1;
               tail_in       = tail_dec;
            end
         end
         FUNC_STEAL: begin
            if (empty) begin
               result.status = STATUS_EMPTY;
            end else begin
               mem_req.rd_en = accept;
               mem_req.addr  = head_ff[ADDR_W-1:0];
               result.take   = 1'b1;
               head_in       = head_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      fill_after  = tail_in - head_in;
      result.fill = FILL_W'(fill_after);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   `WSTD_ASSERT_CK(a_fill_bound, (fill <= CNT_W'(DEPTH - 1)))
   `WSTD_ASSERT_CK(a_pop_empty_clears,
      ((accept && func == FUNC_POP && empty) |=> (head_ff == '0 && tail_ff == '0)))
   `WSTD_ASSERT_CK(a_steal_advances,
      ((accept && func == FUNC_STEAL && !empty) |=>
       (head_ff == CNT_W'($past(head_ff) + 1'b1))))

endmodule
